### rtl/hsg_pkg.sv
package hsg_pkg;

   // list length and field widths
   localparam int HOP_LIST_LEN = 23;
   localparam int ID_W         = 32;
   localparam int ADDR_W       = 40;
   localparam int IDX_W        = 5;
   localparam int CH_W         = 7;
   localparam int FILL_W       = 3;
   localparam int RSP_DATA_W   = 56;

   // generator constants
   localparam logic [31:0] LCG_MUL      = 32'h0019660D;
   localparam logic [31:0] LCG_ADD      = 32'h3c6ef35f;
   localparam logic [7:0]  CHANNEL_SPAN = 8'd125;
   // floor(2^38 / 125): quotient estimate is low by at most one
   localparam logic [31:0] SPAN_RECIP   = 32'h83126E97;
   localparam int          RECIP_SHIFT  = 38;

   // per band channel limits, band is channel bits 6..5
   localparam logic [FILL_W-1:0] BAND_CAP [4] = '{3'd6, 3'd6, 3'd6, 3'd5};

   // controller to datapath
   typedef struct packed {
      logic start;     // seed generator, clear list
      logic run;       // advance the draw pipeline
      logic load_zero; // load the disabled result word
   } hsg_cmd_type;

   // datapath to controller
   typedef struct packed {
      logic out_free;  // output register can take a word this cycle
      logic last_fire; // final channel accepted this cycle
   } hsg_status_type;

   // one address byte from the shifted id, bit 0 is inverse of bit 1
   function automatic logic [7:0] addr_byte(input logic [ID_W-1:0] s);
      addr_byte = {s[7:1], ~s[1]};
   endfunction

   function automatic logic [ADDR_W-1:0] make_address(input logic [ID_W-1:0] id);
      make_address = {addr_byte(id >> 25), addr_byte(id >> 18), addr_byte(id >> 11),
                      addr_byte(id >> 4), 4'hc, id[3:0]};
   endfunction

endpackage

### rtl/hsg_ctrl.sv
module hsg_ctrl import hsg_pkg::*; (
   input  logic           clock,
   input  logic           reset,
   input  logic           req_tvalid,
   output logic           req_tready,
   input  logic           id_zero,
   output hsg_cmd_type    cmd,
   input  hsg_status_type status
);

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_GEN,
      ST_ZERO
   } state_type;

   state_type state_ff, state_in;

   // next state
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_IDLE: begin
            if (req_tvalid) begin
               state_in = id_zero ? ST_ZERO : ST_GEN;
            end
         end
         ST_GEN: begin
            if (status.last_fire) begin
               state_in = ST_IDLE;
            end
         end
         ST_ZERO: begin
            if (status.out_free) begin
               state_in = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   // commands
   assign req_tready    = (state_ff == ST_IDLE);
   assign cmd.start     = (state_ff == ST_IDLE) && req_tvalid && !id_zero;
   assign cmd.run       = (state_ff == ST_GEN);
   assign cmd.load_zero = (state_ff == ST_ZERO);

endmodule

### rtl/hsg_datapath.sv
module hsg_datapath import hsg_pkg::*; (
   input  logic                  clock,
   input  logic                  reset,
   input  logic [ID_W-1:0]       station_id,
   input  hsg_cmd_type           cmd,
   output hsg_status_type        status,
   output logic                  rsp_tvalid,
   input  logic                  rsp_tready,
   output logic [RSP_DATA_W-1:0] rsp_tdata,
   output logic                  rsp_tlast
);

   logic en;

   // generator and draw pipeline
   logic [31:0]      lcg_ff;
   logic             v1_ff, v2_ff, v3_ff;
   logic [63:0]      prod_ff;
   logic [31:0]      x2_ff;
   logic [CH_W-1:0]  ch_ff;

   // list state
   logic [ADDR_W-1:0] addr_ff;
   logic [CH_W-1:0]   list_ff [HOP_LIST_LEN];
   logic [FILL_W-1:0] fill_ff [4];
   logic [IDX_W-1:0]  count_ff;

   // output register
   logic                  out_valid_ff;
   logic [RSP_DATA_W-1:0] out_data_ff;
   logic                  out_last_ff;

   // remainder stage
   logic [25:0] quo;
   logic [7:0]  qlow_x125;
   logic [7:0]  rem_raw;
   logic [7:0]  rem_fix;

   // accept stage
   logic       dup;
   logic [1:0] band;
   logic       full;
   logic       acc;
   logic       is_last;

   assign en = !out_valid_ff || rsp_tready;

   // x mod 125 from the reciprocal product with one correction
   always_comb begin
      quo       = prod_ff[63:RECIP_SHIFT];
      qlow_x125 = 8'(quo[7:0] * CHANNEL_SPAN);
      rem_raw   = x2_ff[7:0] - qlow_x125;
      rem_fix   = (rem_raw >= CHANNEL_SPAN) ? 8'(rem_raw - CHANNEL_SPAN) : rem_raw;
   end

   // duplicate and band checks against the accepted entries
   always_comb begin
      dup = 1'b0;
      for (int i = 0; i < HOP_LIST_LEN; i++) begin
         if ((IDX_W'(i) < count_ff) && (list_ff[i] == ch_ff)) begin
            dup = 1'b1;
         end
      end
      band    = ch_ff[CH_W-1:CH_W-2];
      full    = fill_ff[band] >= BAND_CAP[band];
      acc     = cmd.run && en && v3_ff && !dup && !full;
      is_last = (count_ff == IDX_W'(HOP_LIST_LEN - 1));
   end

   // pipeline control
   always_ff @(posedge clock) begin
      if (reset) begin
         v1_ff    <= 1'b0;
         v2_ff    <= 1'b0;
         v3_ff    <= 1'b0;
         count_ff <= '0;
         for (int b = 0; b < 4; b++) begin
            fill_ff[b] <= '0;
         end
      end else if (cmd.start) begin
         v1_ff    <= 1'b0;
         v2_ff    <= 1'b0;
         v3_ff    <= 1'b0;
         count_ff <= '0;
         for (int b = 0; b < 4; b++) begin
            fill_ff[b] <= '0;
         end
      end else if (cmd.run && en) begin
         v1_ff <= 1'b1;
         v2_ff <= v1_ff;
         v3_ff <= v2_ff;
         if (acc) begin
            count_ff      <= count_ff + 1'b1;
            fill_ff[band] <= fill_ff[band] + 1'b1;
         end
      end
   end

   // pipeline payload
   always_ff @(posedge clock) begin
      if (cmd.start) begin
         lcg_ff  <= station_id;
         addr_ff <= make_address(station_id);
      end else if (cmd.run && en) begin
         lcg_ff  <= lcg_ff * LCG_MUL + LCG_ADD;
         prod_ff <= 64'(lcg_ff) * 64'(SPAN_RECIP);
         x2_ff   <= lcg_ff;
         ch_ff   <= rem_fix[CH_W-1:0];
         if (acc) begin
            list_ff[count_ff] <= ch_ff;
         end
      end
   end

   // output word
   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff <= 1'b0;
      end else if (acc || (cmd.load_zero && en)) begin
         out_valid_ff <= 1'b1;
      end else if (rsp_tready) begin
         out_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (acc) begin
         out_data_ff <= RSP_DATA_W'({ch_ff, count_ff, addr_ff, 1'b1});
         out_last_ff <= is_last;
      end else if (cmd.load_zero && en) begin
         out_data_ff <= '0;
         out_last_ff <= 1'b1;
      end
   end

   assign rsp_tvalid       = out_valid_ff;
   assign rsp_tdata        = out_data_ff;
   assign rsp_tlast        = out_last_ff;
   assign status.out_free  = en;
   assign status.last_fire = acc && is_last;

endmodule

### rtl/hop_sequence_generator_unit.sv
// Hop sequence generator. Each accepted station id word gives a 40-bit link
// address and a list of 23 distinct channels (0..124, at most 6/6/6/5 per band
// 0-31/32-63/64-95/96-124), one result word per channel in list order, the last
// marked by rsp_tlast. An id of zero gives a single all-zero word with tlast set.
// One id is worked on at a time: a channel draw passes a 4-stage pipeline (LCG
// step, reciprocal multiply, mod-125 correction, duplicate/band check), one draw
// a cycle while the output register can take a word; the pipeline stalls while
// the result side holds rsp_tready low. An id needs 23 accepted draws plus any
// rejected ones.
module hop_sequence_generator_unit import hsg_pkg::*; (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_tvalid,
   output logic                  req_tready,
   input  logic [ID_W-1:0]       req_tdata,  // station_id
   output logic                  rsp_tvalid,
   input  logic                  rsp_tready,
   output logic [RSP_DATA_W-1:0] rsp_tdata,  // enabled, radio_address, hop_index,
                                             // hop_channel, zero pad
   output logic                  rsp_tlast   // last_hop
);

   hsg_cmd_type    cmd;
   hsg_status_type status;

   // sequencing
   hsg_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .id_zero    (req_tdata == '0),
      .cmd        (cmd),
      .status     (status)
   );

   // draw pipeline, list and output register
   hsg_datapath u_datapath (
      .clock      (clock),
      .reset      (reset),
      .station_id (req_tdata),
      .cmd        (cmd),
      .status     (status),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tlast  (rsp_tlast)
   );

endmodule

### dv/hop_sequence_generator_unit_tb.sv
module hop_sequence_generator_unit_tb import hsg_pkg::*; ();

   timeunit 1ns;
   timeprecision 1ps;

   localparam int RANDOM_STATIONS = 170;
   localparam int CALM_TAIL       = 30;
   localparam int HOLD_AT_STATION = 30;
   localparam int HOLD_CYCLES     = 400;
   localparam int DRAIN_AT        = 120;
   localparam int DRAIN_CYCLES    = 100;
   localparam int CYCLE_LIMIT     = 400000;
   localparam int REPORT_MAX      = 10;

   // one result word split into its fields
   typedef struct {
      logic              enabled;
      logic [ADDR_W-1:0] radio_address;
      logic [IDX_W-1:0]  hop_index;
      logic [CH_W-1:0]   hop_channel;
      logic              last_hop;
   } hop_word_type;

   // predicts the hop list of each accepted id and checks the result words
   class hop_list_board;
      hop_word_type pending_words[$];
      int           mismatches;
      int           words_checked;
      int           zero_ids;
      int           hop_lists;

      function void note_station(logic [ID_W-1:0] id);
         hop_word_type      w;
         logic [ADDR_W-1:0] addr;
         logic [ID_W-1:0]   lcg;
         logic [ID_W-1:0]   shifted;
         logic [CH_W-1:0]   list [HOP_LIST_LEN];
         logic [FILL_W-1:0] fill [4];
         logic [CH_W-1:0]   candidate;
         int                count;
         int                band;
         int                shifts [4];
         bit                dup;
         shifts = '{4, 11, 18, 25};
         // disabled id gives one all-zero word
         if (id == '0) begin
            w.enabled       = 1'b0;
            w.radio_address = '0;
            w.hop_index     = '0;
            w.hop_channel   = '0;
            w.last_hop      = 1'b1;
            pending_words   = {pending_words, w};
            zero_ids++;
            return;
         end
         // link address: marker byte then four shifted id bytes
         addr[7:0] = {4'hc, id[3:0]};
         for (int k = 0; k < 4; k++) begin
            shifted = id >> shifts[k];
            addr[8*(k+1) +: 8] = {shifted[7:1], ~shifted[1]};
         end
         // draw channels until the list is full
         lcg   = id;
         count = 0;
         for (int b = 0; b < 4; b++) fill[b] = '0;
         while (count < HOP_LIST_LEN) begin
            lcg       = lcg * LCG_MUL + LCG_ADD;
            candidate = CH_W'(lcg % 32'd125);
            dup       = 1'b0;
            for (int i = 0; i < count; i++) begin
               if (list[i] == candidate) dup = 1'b1;
            end
            if (candidate <= 31)      band = 0;
            else if (candidate <= 63) band = 1;
            else if (candidate <= 95) band = 2;
            else                      band = 3;
            if (!dup && fill[band] < BAND_CAP[band]) begin
               fill[band]  = fill[band] + 1'b1;
               list[count] = candidate;
               count++;
            end
         end
         for (int n = 0; n < HOP_LIST_LEN; n++) begin
            w.enabled       = 1'b1;
            w.radio_address = addr;
            w.hop_index     = IDX_W'(n);
            w.hop_channel   = list[n];
            w.last_hop      = (n == HOP_LIST_LEN - 1);
            pending_words   = {pending_words, w};
         end
         hop_lists++;
      endfunction

      function void check_word(logic [RSP_DATA_W-1:0] data, logic last);
         hop_word_type got;
         hop_word_type want;
         got.enabled       = data[0];
         got.radio_address = data[40:1];
         got.hop_index     = data[45:41];
         got.hop_channel   = data[52:46];
         got.last_hop      = last;
         words_checked++;
         if (pending_words.size() == 0) begin
            mismatches++;
            if (mismatches <= REPORT_MAX)
               $display("unexpected word: data %h last %b", data, last);
            return;
         end
         want = pending_words.pop_front();
         if (got.enabled !== want.enabled || got.radio_address !== want.radio_address ||
             got.hop_index !== want.hop_index || got.hop_channel !== want.hop_channel ||
             got.last_hop !== want.last_hop) begin
            mismatches++;
            if (mismatches <= REPORT_MAX) begin
               $display("word %0d mismatch: expected en %b addr %h idx %0d ch %0d last %b",
                        words_checked, want.enabled, want.radio_address, want.hop_index,
                        want.hop_channel, want.last_hop);
               $display("   actual en %b addr %h idx %0d ch %0d last %b",
                        got.enabled, got.radio_address, got.hop_index, got.hop_channel,
                        got.last_hop);
            end
         end
      endfunction

      function int pending();
         return pending_words.size();
      endfunction

      function int failures();
         return mismatches + pending_words.size();
      endfunction
   endclass

   logic                  clock;
   logic                  reset;
   logic                  req_tvalid;
   logic                  req_tready;
   logic [ID_W-1:0]       req_tdata;
   logic                  rsp_tvalid;
   logic                  rsp_tready;
   logic [RSP_DATA_W-1:0] rsp_tdata;
   logic                  rsp_tlast;

   hop_list_board board;
   int            stations_sent;
   int            cycle_count;
   bit            calm;
   bit            hold_done;

   hop_sequence_generator_unit i_dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tlast  (rsp_tlast)
   );

   // clock
   always begin
      clock = 1'b1;
      #1;
      clock = 1'b0;
      #1;
   end

   // run limit
   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("FAIL hop_sequence_generator_unit");
         $finish;
      end
   end

   // result side ready: random bursts of idling plus one long hold-off
   initial begin
      int idle_left;
      int hold_left;
      idle_left  = 0;
      hold_left  = 0;
      hold_done  = 1'b0;
      rsp_tready = 1'b0;
      @(negedge clock);
      while (reset) @(negedge clock);
      forever begin
         if (!hold_done && stations_sent >= HOLD_AT_STATION) begin
            hold_done = 1'b1;
            hold_left = HOLD_CYCLES;
         end
         if (hold_left > 0) begin
            hold_left--;
            rsp_tready <= 1'b0;
         end else if (idle_left > 0) begin
            idle_left--;
            rsp_tready <= 1'b0;
         end else if (!calm && $urandom_range(0, 7) == 0) begin
            idle_left = $urandom_range(1, 4) - 1;
            rsp_tready <= 1'b0;
         end else begin
            rsp_tready <= 1'b1;
         end
         @(negedge clock);
      end
   end

   // result monitor
   initial begin
      forever begin
         @(posedge clock);
         if (!reset && rsp_tvalid && rsp_tready) board.check_word(rsp_tdata, rsp_tlast);
      end
   end

   // offer one id word, with an occasional idle burst ahead of it
   task automatic send_station(input logic [ID_W-1:0] id);
      int gap;
      if (!calm && $urandom_range(0, 3) == 0) begin
         gap = $urandom_range(1, 4);
         repeat (gap) begin
            @(negedge clock);
            req_tvalid <= 1'b0;
         end
      end
      @(negedge clock);
      req_tvalid <= 1'b1;
      req_tdata  <= id;
      do @(posedge clock); while (!req_tready);
      board.note_station(id);
      stations_sent++;
   endtask

   function automatic logic [ID_W-1:0] random_station();
      int pick;
      pick = $urandom_range(0, 11);
      if (pick == 0) return '0;
      if (pick == 1) return ID_W'(1) << $urandom_range(0, ID_W - 1);
      if (pick == 2) return ~(ID_W'(1) << $urandom_range(0, ID_W - 1));
      if (pick == 3) return ID_W'($urandom_range(1, 255));
      return $urandom();
   endfunction

   // stimulus
   initial begin
      logic [ID_W-1:0] directed [$];
      board      = new();
      reset      = 1'b1;
      req_tvalid = 1'b0;
      req_tdata  = '0;
      calm       = 1'b0;
      repeat (10) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // extremes, zero ids back to back, single bits at the address byte edges
      directed = '{32'h0, 32'h1, 32'hffffffff, 32'h0, 32'h0, 32'h80000000, 32'h0000000f,
                   32'h00000010, 32'h55555555, 32'haaaaaaaa, 32'h12345678, 32'hfffffffe,
                   32'h7fffffff, 32'h02000000, 32'h00040000, 32'h00000800, 32'h00000020,
                   32'hfdfbf7ef};
      foreach (directed[i]) send_station(directed[i]);

      for (int n = 0; n < RANDOM_STATIONS; n++) begin
         if (n == RANDOM_STATIONS - CALM_TAIL) calm = 1'b1;
         // let the block drain completely once
         if (n == DRAIN_AT) begin
            @(negedge clock);
            req_tvalid <= 1'b0;
            while (board.pending() != 0) @(posedge clock);
         end
         send_station(random_station());
      end
      @(negedge clock);
      req_tvalid <= 1'b0;

      while (board.pending() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);

      $display("covered %0d ids: %0d full hop lists, %0d disabled ids, %0d words checked",
               stations_sent, board.hop_lists, board.zero_ids, board.words_checked);
      $display("with idle bursts on both sides, a %0d-cycle result hold-off and a full drain",
               HOLD_CYCLES);
      if (board.failures() == 0) begin
         $display("PASS hop_sequence_generator_unit");
      end else begin
         $display("FAIL hop_sequence_generator_unit");
      end
      $finish;
   end

endmodule
